@@ rtl/calf_pkg.sv @@
// Package: shared constants and result layout for the chunked ACK link framer.
`timescale 1ns / 1ps
`default_nettype none
package calf_pkg;

  localparam int CHUNK_BYTES  = 64;
  localparam int HDR_BYTES    = 5;
  localparam int HDR_IDX_W    = $clog2(HDR_BYTES);
  localparam int HDR_FILL_W   = $clog2(HDR_BYTES + 1);
  localparam int CHUNK_FILL_W = $clog2(CHUNK_BYTES + 1);

  localparam logic [7:0] MAGIC0 = 8'hAA;
  localparam logic [7:0] MAGIC1 = 8'h55;
  localparam logic [7:0] CHR_A  = 8'h41;
  localparam logic [7:0] CHR_C  = 8'h43;
  localparam logic [7:0] CHR_K  = 8'h4B;

  localparam logic OP_RX_BYTE = 1'b0;
  localparam logic OP_TX_REQ  = 1'b1;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // Bit positions of result fields in out_tdata
  localparam int OUT_RXV_BIT  = 0;
  localparam int OUT_CE_BIT   = 9;
  localparam int OUT_PE_BIT   = 10;
  localparam int OUT_ACC_BIT  = 11;
  localparam int OUT_CV_BIT   = 12;
  localparam int OUT_LEN_LO   = 29;
  localparam int OUT_LEN_HI   = 35;
  localparam int OUT_DONE_BIT = 36;

  // Declared MSB first: rx_data_valid lands in bit 0
  typedef struct packed {
    logic [2:0]  pad;
    logic        tx_done;
    logic [6:0]  tx_chunk_length;
    logic [15:0] tx_chunk_offset;
    logic        tx_chunk_valid;
    logic        tx_accepted;
    logic        rx_packet_end;
    logic        rx_chunk_end;
    logic [7:0]  rx_data;
    logic        rx_data_valid;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/chunked_ack_link_framer_top.sv @@
// Top level: chunked ACK link framer (transmit chunk sequencer and receive header framer).
`timescale 1ns / 1ps
`default_nettype none
// One input transaction per clock. Each item is held in an input register and
// handled in one pass into the output register. An item that completes a
// valid header releases the HDR_BYTES header bytes one per cycle from the header
// window while the output is not stalled; while they go out the input register
// can take one more item, and in_tready then stays low until the last header
// byte has been loaded. Bytes taken by the ACK matcher, but for the one that
// completes an ACK, and incomplete header bytes produce no output transaction.
// Output backpressure stalls the input register and then in_tready.
module chunked_ack_link_framer_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [calf_pkg::IN_TDATA_W-1:0]   in_tdata,   // rx_byte[7:0], tx_length[23:8]
  input  wire logic                              in_tuser,   // op
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [calf_pkg::OUT_TDATA_W-1:0]       out_tdata,
  // rx_data_valid[0], rx_data[8:1], rx_chunk_end[9], rx_packet_end[10], tx_accepted[11],
  // tx_chunk_valid[12], tx_chunk_offset[28:13], tx_chunk_length[35:29], tx_done[36],
  // zero[39:37]
  output logic                                   out_tlast   // result_last
);

  localparam logic [15:0] CHUNK_LEN16 = 16'(calf_pkg::CHUNK_BYTES);
  localparam logic [calf_pkg::CHUNK_FILL_W-1:0] CHUNK_FULL =
    calf_pkg::CHUNK_FILL_W'(calf_pkg::CHUNK_BYTES);
  localparam logic [calf_pkg::HDR_IDX_W-1:0] HDR_LAST_IDX =
    calf_pkg::HDR_IDX_W'(calf_pkg::HDR_BYTES - 1);
  localparam logic [calf_pkg::HDR_FILL_W-1:0] HDR_LAST_FILL =
    calf_pkg::HDR_FILL_W'(calf_pkg::HDR_BYTES - 1);

  // input register
  logic        s1_valid_r;
  logic        s1_op_r;
  logic [7:0]  s1_byte_r;
  logic [15:0] s1_len_r;

  // output register
  logic              out_valid_r;
  calf_pkg::result_t out_data_r;
  logic              out_last_r;

  // header release burst
  logic                          burst_r, burst_nxt;
  logic [calf_pkg::HDR_IDX_W-1:0] burst_idx_r, burst_idx_nxt;

  // transmit state
  logic        tx_busy_r, tx_busy_nxt;
  logic        awaiting_ack_r, awaiting_ack_nxt;
  logic [15:0] tx_total_r, tx_total_nxt;
  logic [15:0] tx_sent_r, tx_sent_nxt;
  logic [7:0]  ack_h0_r, ack_h0_nxt;
  logic [7:0]  ack_h1_r, ack_h1_nxt;
  logic [1:0]  ack_fill_r, ack_fill_nxt;

  // receive state
  logic [7:0]                        hdr_r   [calf_pkg::HDR_BYTES];
  logic [7:0]                        hdr_nxt [calf_pkg::HDR_BYTES];
  logic [calf_pkg::HDR_FILL_W-1:0]   hdr_fill_r, hdr_fill_nxt;
  logic [16:0]                       rx_expected_r, rx_expected_nxt;
  logic [16:0]                       rx_received_r, rx_received_nxt;
  logic [calf_pkg::CHUNK_FILL_W-1:0] rx_chunk_fill_r, rx_chunk_fill_nxt;

  logic              out_free;
  logic              s1_go;
  calf_pkg::result_t res;
  logic              res_valid;
  logic              res_last;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && !burst_r && out_free;
  assign in_tready = !s1_valid_r || s1_go;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    logic        rel_en;
    logic [7:0]  rel_byte;
    logic        issue;
    logic [15:0] iss_total;
    logic [15:0] iss_sent;
    logic [15:0] rem;
    logic [15:0] clen;
    logic [7:0]  win [calf_pkg::HDR_BYTES];
    logic [16:0] recv_inc;
    logic [calf_pkg::CHUNK_FILL_W-1:0] chunk_inc;
    logic        pe;

    burst_nxt         = burst_r;
    burst_idx_nxt     = burst_idx_r;
    tx_busy_nxt       = tx_busy_r;
    awaiting_ack_nxt  = awaiting_ack_r;
    tx_total_nxt      = tx_total_r;
    tx_sent_nxt       = tx_sent_r;
    ack_h0_nxt        = ack_h0_r;
    ack_h1_nxt        = ack_h1_r;
    ack_fill_nxt      = ack_fill_r;
    hdr_nxt           = hdr_r;
    hdr_fill_nxt      = hdr_fill_r;
    rx_expected_nxt   = rx_expected_r;
    rx_received_nxt   = rx_received_r;
    rx_chunk_fill_nxt = rx_chunk_fill_r;
    res       = '0;
    res_valid = 1'b0;
    res_last  = 1'b0;
    rel_en    = 1'b0;
    rel_byte  = s1_byte_r;
    issue     = 1'b0;
    iss_total = tx_total_r;
    iss_sent  = tx_sent_r;

    for (int i = 0; i < calf_pkg::HDR_BYTES; i++) begin
      win[i] = (hdr_fill_r == calf_pkg::HDR_FILL_W'(i)) ? s1_byte_r : hdr_r[i];
    end

    if (burst_r && out_free) begin
      rel_en   = 1'b1;
      rel_byte = hdr_r[burst_idx_r];
      res_last = (burst_idx_r == HDR_LAST_IDX);
      burst_idx_nxt = burst_idx_r + calf_pkg::HDR_IDX_W'(1);
      if (burst_idx_r == HDR_LAST_IDX) begin
        burst_nxt = 1'b0;
      end
    end else if (s1_go) begin
      if (s1_op_r == calf_pkg::OP_TX_REQ) begin
        res_valid = 1'b1;
        res_last  = 1'b1;
        if (s1_len_r == 16'd0) begin
          res.tx_accepted = 1'b1;
        end else if (!tx_busy_r) begin
          res.tx_accepted = 1'b1;
          tx_busy_nxt     = 1'b1;
          tx_total_nxt    = s1_len_r;
          iss_total       = s1_len_r;
          iss_sent        = 16'd0;
          issue           = 1'b1;
        end
      end else if (awaiting_ack_r) begin
        if (ack_fill_r == 2'd2 && ack_h0_r == calf_pkg::CHR_A &&
            ack_h1_r == calf_pkg::CHR_C && s1_byte_r == calf_pkg::CHR_K) begin
          ack_fill_nxt     = 2'd0;
          awaiting_ack_nxt = 1'b0;
          res_valid        = 1'b1;
          res_last         = 1'b1;
          if (tx_sent_r >= tx_total_r) begin
            tx_busy_nxt  = 1'b0;
            tx_total_nxt = 16'd0;
            tx_sent_nxt  = 16'd0;
            res.tx_done  = 1'b1;
          end else begin
            issue = 1'b1;
          end
        end else begin
          ack_h0_nxt = ack_h1_r;
          ack_h1_nxt = s1_byte_r;
          if (ack_fill_r != 2'd2) begin
            ack_fill_nxt = ack_fill_r + 2'd1;
          end
        end
      end else if (rx_expected_r == 17'd0) begin
        hdr_nxt      = win;
        hdr_fill_nxt = hdr_fill_r + calf_pkg::HDR_FILL_W'(1);
        if (hdr_fill_r == HDR_LAST_FILL) begin
          if (win[0] == calf_pkg::MAGIC0 && win[1] == calf_pkg::MAGIC1) begin
            rx_expected_nxt   = 17'(calf_pkg::HDR_BYTES) + {1'b0, win[4], win[3]};
            rx_received_nxt   = 17'd0;
            rx_chunk_fill_nxt = '0;
            burst_nxt         = 1'b1;
            burst_idx_nxt     = '0;
          end else begin
            for (int i = 0; i < calf_pkg::HDR_BYTES - 1; i++) begin
              hdr_nxt[i] = win[i + 1];
            end
            hdr_fill_nxt = HDR_LAST_FILL;
          end
        end
      end else begin
        rel_en   = 1'b1;
        res_last = 1'b1;
      end
    end

    // chunk command
    rem  = iss_total - iss_sent;
    clen = (rem < CHUNK_LEN16) ? rem : CHUNK_LEN16;
    if (issue) begin
      res.tx_chunk_valid  = 1'b1;
      res.tx_chunk_offset = iss_sent;
      res.tx_chunk_length = clen[6:0];
      tx_sent_nxt         = iss_sent + clen;
      awaiting_ack_nxt    = 1'b1;
      ack_fill_nxt        = 2'd0;
    end

    // byte release
    recv_inc  = rx_received_r + 17'd1;
    chunk_inc = rx_chunk_fill_r + calf_pkg::CHUNK_FILL_W'(1);
    pe        = (recv_inc >= rx_expected_r);
    if (rel_en) begin
      res_valid         = 1'b1;
      res.rx_data_valid = 1'b1;
      res.rx_data       = rel_byte;
      rx_received_nxt   = recv_inc;
      rx_chunk_fill_nxt = chunk_inc;
      if (pe || chunk_inc >= CHUNK_FULL) begin
        res.rx_chunk_end  = 1'b1;
        rx_chunk_fill_nxt = '0;
      end
      if (pe) begin
        res.rx_packet_end = 1'b1;
        rx_expected_nxt   = 17'd0;
        rx_received_nxt   = 17'd0;
        rx_chunk_fill_nxt = '0;
        hdr_fill_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      burst_r         <= 1'b0;
      burst_idx_r     <= '0;
      tx_busy_r       <= 1'b0;
      awaiting_ack_r  <= 1'b0;
      tx_total_r      <= 16'd0;
      tx_sent_r       <= 16'd0;
      ack_h0_r        <= 8'd0;
      ack_h1_r        <= 8'd0;
      ack_fill_r      <= 2'd0;
      hdr_fill_r      <= '0;
      rx_expected_r   <= 17'd0;
      rx_received_r   <= 17'd0;
      rx_chunk_fill_r <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= res_valid;
      end
      burst_r         <= burst_nxt;
      burst_idx_r     <= burst_idx_nxt;
      tx_busy_r       <= tx_busy_nxt;
      awaiting_ack_r  <= awaiting_ack_nxt;
      tx_total_r      <= tx_total_nxt;
      tx_sent_r       <= tx_sent_nxt;
      ack_h0_r        <= ack_h0_nxt;
      ack_h1_r        <= ack_h1_nxt;
      ack_fill_r      <= ack_fill_nxt;
      hdr_fill_r      <= hdr_fill_nxt;
      rx_expected_r   <= rx_expected_nxt;
      rx_received_r   <= rx_received_nxt;
      rx_chunk_fill_r <= rx_chunk_fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r   <= in_tuser;
      s1_byte_r <= in_tdata[7:0];
      s1_len_r  <= in_tdata[23:8];
    end
    if (out_free) begin
      out_data_r <= res;
      out_last_r <= res_last;
    end
    hdr_r <= hdr_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/calf_checker.sv @@
// Checker: port-level assertions for the chunked ACK link framer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module calf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output transaction changed while stalled");

  a_pe_has_ce: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[calf_pkg::OUT_PE_BIT] |-> out_tdata[calf_pkg::OUT_CE_BIT])
    else $error("packet end without chunk end");

  a_tx_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[calf_pkg::OUT_ACC_BIT] || out_tdata[calf_pkg::OUT_CV_BIT] ||
                   out_tdata[calf_pkg::OUT_DONE_BIT]) |-> out_tlast)
    else $error("transmit result not marked last");

  a_chunk_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[calf_pkg::OUT_CV_BIT] |->
      out_tdata[calf_pkg::OUT_LEN_HI:calf_pkg::OUT_LEN_LO] != 7'd0)
    else $error("chunk command with zero length");

  a_rx_tx_apart: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[calf_pkg::OUT_RXV_BIT] |->
      !out_tdata[calf_pkg::OUT_ACC_BIT] && !out_tdata[calf_pkg::OUT_CV_BIT] &&
      !out_tdata[calf_pkg::OUT_DONE_BIT])
    else $error("receive byte mixed with transmit result");

endmodule

bind chunked_ack_link_framer_top calf_checker u_calf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire

@@ test/testbench.sv @@
// Testbench: self-checking stream test of the chunked ACK link framer with random flow control.
`timescale 1ns / 1ps
module testbench;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int ITEM_TARGET = 255;

  typedef struct packed {
    logic        op;
    logic [7:0]  rx_byte;
    logic [15:0] tx_length;
  } link_item_t;

  typedef struct {
    calf_pkg::result_t word;
    logic              last;
  } link_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;

  chunked_ack_link_framer_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  link_item_t   link_items_pending[$];
  link_result_t link_results_due[$];
  int err_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int packets_framed = 0;
  int chunks_issued = 0;
  int transfers_done = 0;

  // Predicted link state
  logic        xmit_busy = 1'b0;
  logic        ack_wait = 1'b0;
  logic [15:0] xmit_total = '0;
  logic [15:0] xmit_sent = '0;
  logic [7:0]  ack_hist[2] = '{8'h00, 8'h00};
  int          ack_cnt = 0;
  logic [7:0]  hdr_win[calf_pkg::HDR_BYTES];
  int          hdr_fill = 0;
  int          pkt_need = 0;
  int          pkt_got = 0;
  int          seg_fill = 0;

  function automatic calf_pkg::result_t next_chunk();
    calf_pkg::result_t r;
    logic [15:0] remain;
    logic [15:0] clen;
    r = '0;
    remain = xmit_total - xmit_sent;
    clen = (remain < calf_pkg::CHUNK_BYTES) ? remain : 16'(calf_pkg::CHUNK_BYTES);
    r.tx_chunk_valid = 1'b1;
    r.tx_chunk_offset = xmit_sent;
    r.tx_chunk_length = clen[6:0];
    xmit_sent = xmit_sent + clen;
    ack_wait = 1'b1;
    ack_cnt = 0;
    chunks_issued++;
    return r;
  endfunction

  function automatic calf_pkg::result_t release_byte(input logic [7:0] b);
    calf_pkg::result_t r;
    logic pkt_end;
    r = '0;
    r.rx_data_valid = 1'b1;
    r.rx_data = b;
    pkt_got++;
    seg_fill++;
    pkt_end = (pkt_got >= pkt_need);
    if (pkt_end || seg_fill >= calf_pkg::CHUNK_BYTES) begin
      r.rx_chunk_end = 1'b1;
      seg_fill = 0;
    end
    if (pkt_end) begin
      r.rx_packet_end = 1'b1;
      pkt_need = 0;
      pkt_got = 0;
      seg_fill = 0;
      hdr_fill = 0;
      packets_framed++;
    end
    return r;
  endfunction

  task automatic predict_link_item(input link_item_t it);
    calf_pkg::result_t rows[$];
    calf_pkg::result_t r;
    logic [7:0]        hdr[calf_pkg::HDR_BYTES];
    link_result_t      e;
    int                i;
    if (it.op == calf_pkg::OP_TX_REQ) begin
      r = '0;
      if (it.tx_length == 16'd0) begin
        r.tx_accepted = 1'b1;
      end else if (!xmit_busy) begin
        xmit_busy = 1'b1;
        xmit_total = it.tx_length;
        xmit_sent = '0;
        r = next_chunk();
        r.tx_accepted = 1'b1;
      end
      rows = {rows, r};
    end else if (ack_wait) begin
      if (ack_cnt >= 2 && ack_hist[0] == calf_pkg::CHR_A &&
          ack_hist[1] == calf_pkg::CHR_C && it.rx_byte == calf_pkg::CHR_K) begin
        ack_cnt = 0;
        ack_wait = 1'b0;
        if (xmit_sent >= xmit_total) begin
          xmit_busy = 1'b0;
          xmit_total = '0;
          xmit_sent = '0;
          r = '0;
          r.tx_done = 1'b1;
          transfers_done++;
        end else begin
          r = next_chunk();
        end
        rows = {rows, r};
      end else begin
        ack_hist[0] = ack_hist[1];
        ack_hist[1] = it.rx_byte;
        if (ack_cnt < 2) ack_cnt++;
      end
    end else if (pkt_need == 0) begin
      if (hdr_fill < calf_pkg::HDR_BYTES) begin
        hdr_win[hdr_fill] = it.rx_byte;
        hdr_fill++;
      end
      if (hdr_fill >= calf_pkg::HDR_BYTES) begin
        if (hdr_win[0] == calf_pkg::MAGIC0 && hdr_win[1] == calf_pkg::MAGIC1) begin
          hdr = hdr_win;
          pkt_need = calf_pkg::HDR_BYTES + int'({hdr[4], hdr[3]});
          pkt_got = 0;
          seg_fill = 0;
          for (i = 0; i < calf_pkg::HDR_BYTES; i++) rows = {rows, release_byte(hdr[i])};
        end else begin
          for (i = 0; i < calf_pkg::HDR_BYTES - 1; i++) hdr_win[i] = hdr_win[i + 1];
          hdr_fill = calf_pkg::HDR_BYTES - 1;
        end
      end
    end else begin
      rows = {rows, release_byte(it.rx_byte)};
    end
    for (i = 0; i < rows.size(); i++) begin
      e.word = rows[i];
      e.last = (i == rows.size() - 1);
      link_results_due = {link_results_due, e};
    end
  endtask

  // Stimulus builders
  function automatic void push_req(input logic [15:0] len);
    link_item_t it;
    it.op = calf_pkg::OP_TX_REQ;
    it.rx_byte = 8'($urandom);
    it.tx_length = len;
    link_items_pending = {link_items_pending, it};
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    link_item_t it;
    it.op = calf_pkg::OP_RX_BYTE;
    it.rx_byte = b;
    it.tx_length = 16'($urandom);
    link_items_pending = {link_items_pending, it};
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == calf_pkg::MAGIC1) b = b + 8'd1;
    return b;
  endfunction

  function automatic void gen_transfer();
    int len;
    int n_chunks;
    int c;
    int k;
    len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, calf_pkg::CHUNK_BYTES)
                                      : $urandom_range(1, 200);
    n_chunks = (len + calf_pkg::CHUNK_BYTES - 1) / calf_pkg::CHUNK_BYTES;
    push_req(16'(len));
    for (c = 0; c < n_chunks; c++) begin
      for (k = $urandom_range(0, 3); k > 0; k--) push_byte(8'($urandom));
      if ($urandom_range(0, 4) == 0) push_req(16'($urandom_range(1, 65535)));
      if ($urandom_range(0, 9) == 0) push_req(16'd0);
      push_byte(calf_pkg::CHR_A);
      push_byte(calf_pkg::CHR_C);
      push_byte(calf_pkg::CHR_K);
    end
  endfunction

  function automatic void push_rx(input logic [7:0] b);
    if ($urandom_range(0, 39) == 0) gen_transfer();
    push_byte(b);
  endfunction

  function automatic void gen_packet(input int min_len, input int max_len);
    int plen;
    int k;
    for (k = $urandom_range(0, 3); k > 0; k--) push_rx(noise_byte());
    if ($urandom_range(0, 9) == 0) begin
      push_rx(calf_pkg::MAGIC0);
      push_rx(noise_byte());
    end
    plen = $urandom_range(min_len, max_len);
    push_rx(calf_pkg::MAGIC0);
    push_rx(calf_pkg::MAGIC1);
    push_rx(8'($urandom));
    push_rx(plen[7:0]);
    push_rx(plen[15:8]);
    for (k = 0; k < plen; k++) push_rx(8'($urandom));
  endfunction

  // Driver: bursts with random gaps
  int burst_left = 1;
  int gap_left = 0;
  link_item_t drv_item;

  always @(posedge clk) begin : driver
    link_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= 1'b0;
      burst_left <= 1;
      gap_left <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_link_item(drv_item);
        items_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (link_items_pending.size() != 0) begin
          nxt = link_items_pending.pop_front();
          drv_item <= nxt;
          in_tdata <= {nxt.tx_length, nxt.rx_byte};
          in_tuser <= nxt.op;
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 32);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern
  logic [15:0] ready_pattern = 16'hFFFF;
  logic [3:0]  ready_pos = '0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      ready_pos <= '0;
    end else begin
      out_tready <= ready_pattern[ready_pos];
      ready_pos <= ready_pos + 4'd1;
      if (ready_pos == 4'd15) begin
        case ($urandom_range(0, 3))
          0: ready_pattern <= 16'hFFFF;
          1: ready_pattern <= 16'($urandom | $urandom);
          2: ready_pattern <= 16'($urandom);
          default: ready_pattern <= 16'($urandom & $urandom);
        endcase
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    calf_pkg::result_t got;
    link_result_t      want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (link_results_due.size() == 0) begin
        $error("result with nothing expected: tdata 0x%0h tlast %0b", out_tdata, out_tlast);
        err_count++;
      end else begin
        want = link_results_due.pop_front();
        check_field("rx_data_valid", want.word.rx_data_valid, got.rx_data_valid);
        check_field("rx_data", want.word.rx_data, got.rx_data);
        check_field("rx_chunk_end", want.word.rx_chunk_end, got.rx_chunk_end);
        check_field("rx_packet_end", want.word.rx_packet_end, got.rx_packet_end);
        check_field("tx_accepted", want.word.tx_accepted, got.tx_accepted);
        check_field("tx_chunk_valid", want.word.tx_chunk_valid, got.tx_chunk_valid);
        check_field("tx_chunk_offset", want.word.tx_chunk_offset, got.tx_chunk_offset);
        check_field("tx_chunk_length", want.word.tx_chunk_length, got.tx_chunk_length);
        check_field("tx_done", want.word.tx_done, got.tx_done);
        check_field("pad", 0, got.pad);
        check_field("result_last", want.last, out_tlast);
        results_checked++;
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    // transmit: empty request, chunked transfer, refusal while busy, ACK matching
    push_req(16'd0);
    push_req(16'd70);
    push_req(16'hFFFF);
    push_req(16'd0);
    push_byte(calf_pkg::CHR_K);
    push_byte(calf_pkg::CHR_A);
    push_byte(calf_pkg::CHR_C);
    push_byte(calf_pkg::CHR_K);
    push_byte(calf_pkg::CHR_K);
    push_byte(calf_pkg::CHR_A);
    push_byte(calf_pkg::CHR_C);
    push_byte(calf_pkg::CHR_K);
    // receive: misaligned magic then one-byte payload
    push_byte(calf_pkg::MAGIC1);
    push_byte(calf_pkg::MAGIC0);
    push_byte(calf_pkg::MAGIC1);
    push_byte(8'h00);
    push_byte(8'h01);
    push_byte(8'h00);
    push_byte(8'hFF);
    // receive: empty payload
    push_byte(calf_pkg::MAGIC0);
    push_byte(calf_pkg::MAGIC1);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'h00);

    gen_packet(calf_pkg::CHUNK_BYTES, 140);
    while (link_items_pending.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 19) == 0) push_req(16'd0);
      if ($urandom_range(0, 9) < 3) gen_transfer();
      else if ($urandom_range(0, 6) == 0) gen_packet(60, 140);
      else gen_packet(0, 24);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (link_items_pending.size() != 0 || in_tvalid || link_results_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d link items: %0d packets framed, %0d chunks issued, %0d transfers done",
             items_sent, packets_framed, chunks_issued, transfers_done);
    $display("Compared %0d result transactions, %0d mismatches", results_checked, err_count);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/calf_pkg.sv
rtl/chunked_ack_link_framer_top.sv
rtl/calf_checker.sv
test/testbench.sv
